### rtl/regression_slope_accumulator_top_defines.svh
// assertion macros shared by the regression slope accumulator rtl
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef REGRESSION_SLOPE_ACCUMULATOR_TOP_DEFINES_SVH
`define REGRESSION_SLOPE_ACCUMULATOR_TOP_DEFINES_SVH

// plain implication checked every cycle out of reset
`define RSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define RSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rsa_pkg.sv
// shared constants, types and queue entry layout for the slope accumulator
// no dependencies; imported by every rtl module of the block
package rsa_pkg;

  localparam int unsigned MAX_SAMPLES  = 1048576;
  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned IN_W         = 16;
  localparam int unsigned SAMPLE_SHIFT = IN_W - SAMPLE_BITS;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned SLOPE_W      = 32;

  localparam int unsigned CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W   = SAMPLE_BITS + CNT_W;
  localparam int unsigned SQ_W    = 2 * SAMPLE_BITS + CNT_W;
  localparam int unsigned PROD_W  = 2 * SUM_W + 1;
  localparam int unsigned MAG_B_W = SUM_W;
  localparam int unsigned MUL_STEPS = MAG_B_W;
  localparam int unsigned DIVD_W  = PROD_W + FRAC_BITS;
  localparam int unsigned DIV_STEPS = DIVD_W;
  localparam int unsigned STEP_W  = $clog2(DIVD_W);

  // queue depth must be a power of two, pointers wrap on their own
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef logic signed [IN_W-1:0]    sample_t;
  typedef logic signed [2*IN_W-1:0]  prod_t;
  typedef logic        [CNT_W-1:0]   cnt_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [SQ_W-1:0]    sq_t;
  typedef logic signed [PROD_W-1:0]  acc_t;

  typedef struct packed {
    sample_t y;
    sample_t x;
    prod_t   xx;
    prod_t   xy;
    logic    present;
    logic    last;
  } entry_t;

  typedef struct packed {
    cnt_t count;
    sum_t sy;
    sum_t sx;
    sq_t  sxx;
    sq_t  sxy;
    logic dropped;
  } sums_t;

endpackage

### rtl/rsa_front.sv
// input side: sample sign extension, pair products and item classification
// depends on rsa_pkg; feeds the entry queue
module rsa_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rsa_pkg::sample_t dependent_value_i,
  input  rsa_pkg::sample_t independent_value_i,
  input  logic             pair_present_i,
  input  logic             last_item_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output rsa_pkg::entry_t  q_data_o
);
  import rsa_pkg::*;

  sample_t y_shl, x_shl, y_ext, x_ext;

  assign y_shl = dependent_value_i <<< SAMPLE_SHIFT;
  assign x_shl = independent_value_i <<< SAMPLE_SHIFT;
  assign y_ext = y_shl >>> SAMPLE_SHIFT;
  assign x_ext = x_shl >>> SAMPLE_SHIFT;

  assign in_ready_o = !q_full_i;

  // items with no pair and no close have no effect and never enter the queue
  assign q_push_o = in_valid_i && !q_full_i && (pair_present_i || last_item_i);

  always_comb begin
    q_data_o.y       = y_ext;
    q_data_o.x       = x_ext;
    q_data_o.xx      = prod_t'(x_ext) * prod_t'(x_ext);
    q_data_o.xy      = prod_t'(x_ext) * prod_t'(y_ext);
    q_data_o.present = pair_present_i;
    q_data_o.last    = last_item_i;
  end

endmodule

### rtl/rsa_fifo.sv
// short entry queue between the front and the accumulator
// depends on rsa_pkg for depth and entry layout
module rsa_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rsa_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output rsa_pkg::entry_t data_o
);
  import rsa_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   fill_q;

  assign full_o  = (fill_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/rsa_accum.sv
// running count and sums of one group, one queue entry per cycle unless a last entry waits
// for the solver to go idle; depends on rsa_pkg; hands the closed group to the solver
module rsa_accum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  rsa_pkg::entry_t data_i,
  output logic            pop_o,
  input  logic            solver_ready_i,
  output logic            start_o,
  output rsa_pkg::sums_t  sums_o
);
  import rsa_pkg::*;

  sums_t sums_q, sums_d, upd;
  logic  at_limit, take;

  assign at_limit = (sums_q.count == CNT_W'(MAX_SAMPLES));
  assign take     = data_i.present && !at_limit;
  assign pop_o    = !empty_i && (!data_i.last || solver_ready_i);
  assign start_o  = pop_o && data_i.last;
  assign sums_o   = upd;

  always_comb begin
    upd = sums_q;
    if (take) begin
      upd.count = sums_q.count + 1'b1;
      upd.sy    = sums_q.sy + sum_t'(data_i.y);
      upd.sx    = sums_q.sx + sum_t'(data_i.x);
      upd.sxx   = sums_q.sxx + sq_t'(data_i.xx);
      upd.sxy   = sums_q.sxy + sq_t'(data_i.xy);
    end
    if (data_i.present && at_limit) begin
      upd.dropped = 1'b1;
    end
  end

  always_comb begin
    sums_d = sums_q;
    if (pop_o) begin
      sums_d = data_i.last ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q <= '0;
    end else begin
      sums_q <= sums_d;
    end
  end

endmodule

### rtl/rsa_solver.sv
// slope of a closed group: shift-add products, restoring divide, round, clip
// depends on rsa_pkg and the assertion macro header; holds the result register
`include "regression_slope_accumulator_top_defines.svh"

module rsa_solver (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  rsa_pkg::sums_t                     sums_i,
  output logic                               ready_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rsa_pkg::SLOPE_W-1:0] slope_value_o,
  output logic                               result_null_o,
  output logic                               saturated_o,
  output logic                               overflowed_o
);
  import rsa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_MUL    = 6'b000100,
    S_DIVSET = 6'b001000,
    S_DIV    = 6'b010000,
    S_ROUND  = 6'b100000
  } state_e;

  // products in order: n*sxy, sx*sy, n*sxx, sx*sx; odd ones are subtracted
  localparam logic [1:0] TERM_NXY = 2'd0;
  localparam logic [1:0] TERM_XY  = 2'd1;
  localparam logic [1:0] TERM_NXX = 2'd2;
  localparam logic [1:0] TERM_XX  = 2'd3;

  state_e              state_q, state_d;
  logic [1:0]          term_q;
  logic [STEP_W-1:0]   step_q;
  sums_t               snap_q;
  acc_t                num_q, den_q;
  logic [PROD_W-1:0]   a_q;
  logic [MAG_B_W-1:0]  b_q;
  logic                neg_q;
  logic [DIVD_W-1:0]   dq_q;
  logic [PROD_W-1:0]   rem_q;
  logic                qneg_q, null_q;
  logic                out_valid_q, out_null_q, out_sat_q, out_ovf_q;
  logic [SLOPE_W-1:0]  out_slope_q;

  sq_t                 op_a;
  sum_t                op_b;
  logic [SQ_W-1:0]     a_mag;
  logic [MAG_B_W-1:0]  b_mag;
  logic                term_neg;
  logic [PROD_W-1:0]   addend;
  acc_t                acc_sel, acc_nxt;
  logic [PROD_W-1:0]   num_mag;
  logic [PROD_W:0]     trial, dvs, diff;
  logic                ge, rnd, sat;
  logic [DIVD_W:0]     q1;
  logic [SLOPE_W-1:0]  lim, qclip, res_slope;
  logic                mul_last, div_last, out_load;

  always_comb begin
    case (term_q)
      TERM_NXY: begin
        op_a = snap_q.sxy;
        op_b = sum_t'({1'b0, snap_q.count});
      end
      TERM_XY: begin
        op_a = sq_t'(snap_q.sy);
        op_b = snap_q.sx;
      end
      TERM_NXX: begin
        op_a = snap_q.sxx;
        op_b = sum_t'({1'b0, snap_q.count});
      end
      default: begin
        op_a = sq_t'(snap_q.sx);
        op_b = snap_q.sx;
      end
    endcase
  end

  assign a_mag    = op_a[SQ_W-1] ? SQ_W'(-op_a) : SQ_W'(op_a);
  assign b_mag    = op_b[SUM_W-1] ? MAG_B_W'(-op_b) : MAG_B_W'(op_b);
  assign term_neg = op_a[SQ_W-1] ^ op_b[SUM_W-1] ^ term_q[0];

  assign addend  = b_q[0] ? a_q : '0;
  assign acc_sel = term_q[1] ? den_q : num_q;
  assign acc_nxt = neg_q ? acc_sel - acc_t'(addend) : acc_sel + acc_t'(addend);

  assign num_mag = num_q[PROD_W-1] ? PROD_W'(-num_q) : PROD_W'(num_q);

  assign trial = {rem_q, dq_q[DIVD_W-1]};
  assign dvs   = {1'b0, den_q};
  assign ge    = (trial >= dvs);
  assign diff  = trial - dvs;

  assign rnd   = ({rem_q, 1'b0} >= dvs);
  assign q1    = {1'b0, dq_q} + (DIVD_W+1)'(rnd);
  assign lim   = qneg_q ? {1'b1, {(SLOPE_W-1){1'b0}}} : {1'b0, {(SLOPE_W-1){1'b1}}};
  assign sat   = (q1 > (DIVD_W+1)'(lim));
  assign qclip = sat ? lim : q1[SLOPE_W-1:0];
  assign res_slope = qneg_q ? (~qclip + 1'b1) : qclip;

  assign mul_last = (step_q == STEP_W'(MUL_STEPS - 1));
  assign div_last = (step_q == STEP_W'(DIV_STEPS - 1));
  assign out_load = (state_q == S_ROUND) && (!out_valid_q || out_ready_i);

  assign ready_o       = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign slope_value_o = out_slope_q;
  assign result_null_o = out_null_q;
  assign saturated_o   = out_sat_q;
  assign overflowed_o  = out_ovf_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        if (mul_last) begin
          state_d = (term_q == TERM_XX) ? S_DIVSET : S_LOAD;
        end
      end
      S_DIVSET: begin
        state_d = (den_q == '0) ? S_ROUND : S_DIV;
      end
      S_DIV: begin
        if (div_last) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      term_q      <= TERM_NXY;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && start_i) begin
        term_q <= TERM_NXY;
      end else if (state_q == S_MUL && mul_last) begin
        term_q <= term_q + 1'b1;
      end
      if (state_q == S_LOAD || state_q == S_DIVSET) begin
        step_q <= '0;
      end else if (state_q == S_MUL || state_q == S_DIV) begin
        step_q <= step_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          snap_q <= sums_i;
          num_q  <= '0;
          den_q  <= '0;
        end
      end
      S_LOAD: begin
        a_q   <= PROD_W'(a_mag);
        b_q   <= b_mag;
        neg_q <= term_neg;
      end
      S_MUL: begin
        if (term_q[1]) begin
          den_q <= acc_nxt;
        end else begin
          num_q <= acc_nxt;
        end
        a_q <= a_q << 1;
        b_q <= b_q >> 1;
      end
      S_DIVSET: begin
        null_q <= (den_q == '0);
        qneg_q <= num_q[PROD_W-1];
        dq_q   <= DIVD_W'(num_mag) << FRAC_BITS;
        rem_q  <= '0;
      end
      S_DIV: begin
        rem_q <= ge ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
        dq_q  <= {dq_q[DIVD_W-2:0], ge};
      end
      S_ROUND: begin
        if (out_load) begin
          out_slope_q <= null_q ? '0 : res_slope;
          out_null_q  <= null_q;
          out_sat_q   <= !null_q && sat;
          out_ovf_q   <= snap_q.dropped;
        end
      end
      default: begin
      end
    endcase
  end

  `RSA_ASSERT_IMPL(a_start_idle, start_i, state_q == S_IDLE, "group closed while solver busy")
  `RSA_ASSERT_IMPL(a_den_nonneg, state_q == S_DIVSET, !den_q[PROD_W-1], "negative variance term")
  `RSA_ASSERT_IMPL(a_rem_bound, state_q == S_DIV, rem_q < $unsigned(den_q), "remainder above divisor")
  `RSA_ASSERT_IMPL(a_null_clean, out_valid_q && out_null_q, !out_sat_q && (out_slope_q == '0), "null result with slope")
  `RSA_ASSERT_NEXT(a_round_done, out_load, state_q == S_IDLE && out_valid_q, "result load lost")

endmodule

### rtl/regression_slope_accumulator_top.sv
// top level of the least-squares slope accumulator
// depends on rsa_pkg, rsa_front, rsa_fifo, rsa_accum and rsa_solver
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_ready_o   | dependent, independent, pair_present, last_item
//  out     | output    | out_valid_o/out_ready_i | slope_value, result_null, saturated, overflowed
//
// items that are not marked last go in one per cycle, limited by the four-entry queue
// a last item waits in the queue until the solver is idle, then the solver runs its
// shift-add and divide steps; the next group accumulates while the solver works;
// a null result skips the divide
// reset clears the sums, the queue and the result valid flag; no clearing pass
module regression_slope_accumulator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  rsa_pkg::sample_t                   dependent_value_i,
  input  rsa_pkg::sample_t                   independent_value_i,
  input  logic                               pair_present_i,
  input  logic                               last_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rsa_pkg::SLOPE_W-1:0] slope_value_o,
  output logic                               result_null_o,
  output logic                               saturated_o,
  output logic                               overflowed_o
);
  import rsa_pkg::*;

  entry_t push_data, head_data;
  sums_t  sums;
  logic   q_full, q_empty, q_push, q_pop, start, solver_ready;

  rsa_front u_front (
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .dependent_value_i   (dependent_value_i),
    .independent_value_i (independent_value_i),
    .pair_present_i      (pair_present_i),
    .last_item_i         (last_item_i),
    .q_full_i            (q_full),
    .q_push_o            (q_push),
    .q_data_o            (push_data)
  );

  rsa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (head_data)
  );

  rsa_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .data_i         (head_data),
    .pop_o          (q_pop),
    .solver_ready_i (solver_ready),
    .start_o        (start),
    .sums_o         (sums)
  );

  rsa_solver u_solver (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .sums_i        (sums),
    .ready_o       (solver_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .slope_value_o (slope_value_o),
    .result_null_o (result_null_o),
    .saturated_o   (saturated_o),
    .overflowed_o  (overflowed_o)
  );

endmodule

### tb/sv/rsa_slope_checker.sv
// checker for the regression slope accumulator: watches both channels, keeps its own
// running sums per group and compares every slope result with the predicted one
// depends on rsa_pkg for the sample and slope widths, the sample limit and the fraction bits
module rsa_slope_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  rsa_pkg::sample_t                   dependent_value_i,
  input  rsa_pkg::sample_t                   independent_value_i,
  input  logic                               pair_present_i,
  input  logic                               last_item_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [rsa_pkg::SLOPE_W-1:0] slope_value_i,
  input  logic                               result_null_i,
  input  logic                               saturated_i,
  input  logic                               overflowed_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [rsa_pkg::SLOPE_W-1:0] slope;
    logic                               is_null;
    logic                               sat;
    logic                               dropped;
  } slope_result_t;

  slope_result_t slope_expected_q[$];
  int            fails = 0;

  longint grp_count;
  longint grp_sy;
  longint grp_sx;
  longint grp_sxx;
  longint grp_sxy;
  logic   grp_dropped;

  assign fail_count_o = fails;

  function automatic longint widen_sample(rsa_pkg::sample_t raw);
    logic signed [rsa_pkg::SAMPLE_BITS-1:0] s;
    s = raw[rsa_pkg::SAMPLE_BITS-1:0];
    return s;
  endfunction

  function automatic slope_result_t solve_slope();
    logic signed [127:0] n_w, sy_w, sx_w, sxx_w, sxy_w;
    logic signed [127:0] num, den;
    logic [255:0]        mag, quo, rmd;
    logic                neg;
    slope_result_t       r;
    n_w   = grp_count;
    sy_w  = grp_sy;
    sx_w  = grp_sx;
    sxx_w = grp_sxx;
    sxy_w = grp_sxy;
    num = n_w * sxy_w - sx_w * sy_w;
    den = n_w * sxx_w - sx_w * sx_w;
    r = '0;
    r.dropped = grp_dropped;
    if (grp_count == 0 || den == 0) begin
      r.is_null = 1'b1;
    end else begin
      neg = num < 0;
      mag = neg ? -num : num;
      mag = mag << rsa_pkg::FRAC_BITS;
      quo = mag / den;
      rmd = mag % den;
      if (2 * rmd >= den) quo = quo + 1;
      if (neg) begin
        if (quo > 256'h8000_0000) begin
          r.sat   = 1'b1;
          r.slope = 32'h8000_0000;
        end else begin
          r.slope = -quo[31:0];
        end
      end else begin
        if (quo > 256'h7FFF_FFFF) begin
          r.sat   = 1'b1;
          r.slope = 32'h7FFF_FFFF;
        end else begin
          r.slope = quo[31:0];
        end
      end
    end
    return r;
  endfunction

  task automatic accumulate_pair(rsa_pkg::sample_t y_raw, rsa_pkg::sample_t x_raw);
    longint y, x;
    y = widen_sample(y_raw);
    x = widen_sample(x_raw);
    if (grp_count >= rsa_pkg::MAX_SAMPLES) begin
      grp_dropped = 1'b1;
    end else begin
      grp_count++;
      grp_sy  += y;
      grp_sx  += x;
      grp_sxx += x * x;
      grp_sxy += x * y;
    end
  endtask

  task automatic clear_group();
    grp_count   = 0;
    grp_sy      = 0;
    grp_sx      = 0;
    grp_sxx     = 0;
    grp_sxy     = 0;
    grp_dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slope_result_t exp_r;
    if (!rst_ni) begin
      clear_group();
      slope_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (pair_present_i) accumulate_pair(dependent_value_i, independent_value_i);
        if (last_item_i) begin
          slope_expected_q.push_back(solve_slope());
          clear_group();
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (slope_expected_q.size() == 0) begin
          $display("%0t: unexpected result: slope %h null %b sat %b ovf %b", $realtime,
                   slope_value_i, result_null_i, saturated_i, overflowed_i);
          fails++;
        end else begin
          exp_r = slope_expected_q.pop_front();
          if (slope_value_i !== exp_r.slope) begin
            $display("%0t: slope_value expected %h actual %h", $realtime, exp_r.slope,
                     slope_value_i);
            fails++;
          end
          if (result_null_i !== exp_r.is_null) begin
            $display("%0t: result_null expected %b actual %b", $realtime, exp_r.is_null,
                     result_null_i);
            fails++;
          end
          if (saturated_i !== exp_r.sat) begin
            $display("%0t: saturated expected %b actual %b", $realtime, exp_r.sat,
                     saturated_i);
            fails++;
          end
          if (overflowed_i !== exp_r.dropped) begin
            $display("%0t: overflowed expected %b actual %b", $realtime, exp_r.dropped,
                     overflowed_i);
            fails++;
          end
        end
      end
      pending_o <= slope_expected_q.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
// stimulus and verdict for the regression slope accumulator
// depends on rsa_pkg, regression_slope_accumulator_top and rsa_slope_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef enum int unsigned {
    VAL_FULL,
    VAL_NEAR,
    VAL_FIXED,
    VAL_EDGE,
    VAL_TINY
  } value_style_e;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  rsa_pkg::sample_t                   dependent_value_i;
  rsa_pkg::sample_t                   independent_value_i;
  logic                               pair_present_i;
  logic                               last_item_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic signed [rsa_pkg::SLOPE_W-1:0] slope_value_o;
  logic                               result_null_o;
  logic                               saturated_o;
  logic                               overflowed_o;

  int          fail_count;
  int          results_pending;
  int unsigned cycle_count = 0;
  int unsigned ready_hold  = 0;
  int unsigned burst_left  = 0;

  regression_slope_accumulator_top DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .dependent_value_i   (dependent_value_i),
    .independent_value_i (independent_value_i),
    .pair_present_i      (pair_present_i),
    .last_item_i         (last_item_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .slope_value_o       (slope_value_o),
    .result_null_o       (result_null_o),
    .saturated_o         (saturated_o),
    .overflowed_o        (overflowed_o)
  );

  rsa_slope_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .dependent_value_i   (dependent_value_i),
    .independent_value_i (independent_value_i),
    .pair_present_i      (pair_present_i),
    .last_item_i         (last_item_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .slope_value_i       (slope_value_o),
    .result_null_i       (result_null_o),
    .saturated_i         (saturated_o),
    .overflowed_i        (overflowed_o),
    .fail_count_o        (fail_count),
    .pending_o           (results_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (ready_hold == 0) begin
      if ($urandom_range(0, 9) < 6) begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(0, 40);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(0, 12);
      end
    end else begin
      ready_hold--;
    end
  end

  function automatic rsa_pkg::sample_t pick_value(value_style_e style, rsa_pkg::sample_t base);
    case (style)
      VAL_FULL:  return 16'($urandom);
      VAL_NEAR:  return base + 16'($urandom_range(0, 3));
      VAL_FIXED: return base;
      VAL_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default:   return 16'($urandom_range(0, 64)) - 16'd32;
    endcase
  endfunction

  // one item per call, with a random gap in front of each new burst
  task automatic push_item(rsa_pkg::sample_t y, rsa_pkg::sample_t x, logic present,
                           logic last);
    int unsigned gap_len;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap_len) begin
        @(negedge clk_i);
        in_valid_i          <= 1'b0;
        dependent_value_i   <= 16'($urandom);
        independent_value_i <= 16'($urandom);
        pair_present_i      <= 1'($urandom);
        last_item_i         <= 1'($urandom);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i          <= 1'b1;
    dependent_value_i   <= y;
    independent_value_i <= x;
    pair_present_i      <= present;
    last_item_i         <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic run_directed();
    push_item(16'h0000, 16'h0000, 1'b0, 1'b1);
    push_item(16'h0100, 16'h0100, 1'b1, 1'b1);
    push_item(16'h7FFF, 16'h8000, 1'b1, 1'b0);
    push_item(16'h1234, 16'h5678, 1'b0, 1'b0);
    push_item(16'h8000, 16'h7FFF, 1'b1, 1'b1);
    push_item(16'h0100, 16'h1234, 1'b1, 1'b0);
    push_item(16'hF000, 16'h1234, 1'b1, 1'b0);
    push_item(16'h7FFF, 16'h1234, 1'b1, 1'b1);
    push_item(16'h8000, 16'h0000, 1'b1, 1'b0);
    push_item(16'h7FFF, 16'h0001, 1'b1, 1'b1);
    push_item(16'h7FFF, 16'h0000, 1'b1, 1'b0);
    push_item(16'h8000, 16'h0001, 1'b1, 1'b1);
    push_item(16'h0000, 16'h0000, 1'b1, 1'b0);
    push_item(16'h0100, 16'h0100, 1'b1, 1'b0);
    push_item(16'h0300, 16'h0200, 1'b1, 1'b0);
    push_item(16'hFFFF, 16'h8000, 1'b0, 1'b1);
    push_item(16'h1111, 16'h2222, 1'b0, 1'b0);
    push_item(16'h3333, 16'h4444, 1'b0, 1'b1);
    push_item(16'h8000, 16'h8000, 1'b1, 1'b0);
    push_item(16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
  endtask

  task automatic run_random_groups(int unsigned item_budget);
    int unsigned      sent;
    int unsigned      len;
    int unsigned      absent_pct;
    value_style_e     x_style;
    value_style_e     y_style;
    rsa_pkg::sample_t x_base;
    rsa_pkg::sample_t y_base;
    logic             present;
    sent = 0;
    while (sent < item_budget) begin
      len        = $urandom_range(0, 15);
      x_style    = value_style_e'($urandom_range(0, 4));
      y_style    = value_style_e'($urandom_range(0, 4));
      x_base     = 16'($urandom);
      y_base     = 16'($urandom);
      absent_pct = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(0, 30);
      for (int i = 0; i <= len; i++) begin
        present = $urandom_range(1, 100) > absent_pct;
        push_item(pick_value(y_style, y_base), pick_value(x_style, x_base), present,
                  i == len);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    dependent_value_i   = '0;
    independent_value_i = '0;
    pair_present_i      = 1'b0;
    last_item_i         = 1'b0;
    out_ready_i         = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(posedge clk_i);
    burst_left = 0;

    run_random_groups(RANDOM_ITEMS);
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (results_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
